// ----- rtl/afr_pkg.sv -----
// ----------------------------------------------------------------------------
// afr_pkg: shared types and constants of the addressed frame receiver
// Widths of the link byte and header words, the header length, and the
// result beat type that travels from the deframer to the output buffer.
// ----------------------------------------------------------------------------
package afr_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned OFFSET_W     = 31;
  localparam int unsigned HEADER_BYTES = 12;

  // Header byte positions: address and length fill the first two words,
  // status fills the third.
  localparam logic [OFFSET_W-1:0] STATUS_FIRST = OFFSET_W'(8);
  localparam logic [OFFSET_W-1:0] HEADER_LAST  = OFFSET_W'(HEADER_BYTES - 1);

  typedef struct packed {
    logic        [BYTE_W-1:0]   payload_byte;
    logic        [OFFSET_W-1:0] byte_offset;
    logic                       last_byte;
    logic signed [WORD_W-1:0]   frame_length;
    logic signed [WORD_W-1:0]   frame_status;
  } afr_result_t;

endpackage

// ----- rtl/afr_if.sv -----
// ----------------------------------------------------------------------------
// afr_if: channel interfaces of the addressed frame receiver
// Received byte channel, payload result channel and the address write port.
// ----------------------------------------------------------------------------
interface afr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_payload_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  payload_byte;
  logic        [30:0] byte_offset;
  logic               last_byte;
  logic signed [31:0] frame_length;
  logic signed [31:0] frame_status;

  modport source (output valid, output payload_byte, output byte_offset,
                  output last_byte, output frame_length, output frame_status,
                  input ready);
  modport sink   (input valid, input payload_byte, input byte_offset,
                  input last_byte, input frame_length, input frame_status,
                  output ready);
endinterface

interface afr_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] own_address;

  modport source (output valid, output own_address, input ready);
  modport sink   (input valid, input own_address, output ready);
endinterface

// ----- rtl/afr_deframer.sv -----
// ----------------------------------------------------------------------------
// afr_deframer: header collection and payload counting
// Holds the frame state and works out, for each accepted byte, the next
// state and the result beat that the byte causes, if any.
// ----------------------------------------------------------------------------
module afr_deframer
  import afr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic [BYTE_W-1:0]        rx_byte,
  input  logic signed [WORD_W-1:0] own_address,
  output logic                     res_valid,
  output afr_result_t              res
);

  logic                in_payload;
  logic                in_payload_next;
  logic [OFFSET_W-1:0] byte_count;
  logic [OFFSET_W-1:0] byte_count_next;
  logic [63:0]         header_shift;
  logic [WORD_W-1:0]   status_word;

  logic [WORD_W-1:0]   dest_address;
  logic [WORD_W-1:0]   payload_length;
  logic [WORD_W-1:0]   count_plus;
  logic                last;
  logic                addr_match;

  // Address and length words stay in the shift register for the whole payload.
  assign dest_address   = header_shift[WORD_W-1:0];
  assign payload_length = header_shift[63:WORD_W];
  assign count_plus     = {1'b0, byte_count} + WORD_W'(1);
  // A negative length ends the frame on its first payload byte.
  assign last       = payload_length[WORD_W-1] || (count_plus >= payload_length);
  assign addr_match = (dest_address == own_address) || (dest_address == '0);

  always_comb begin
    in_payload_next = in_payload;
    byte_count_next = byte_count;
    if (!in_payload) begin
      if (byte_count >= HEADER_LAST) begin
        in_payload_next = 1'b1;
        byte_count_next = '0;
      end else begin
        byte_count_next = byte_count + OFFSET_W'(1);
      end
    end else if (last) begin
      in_payload_next = 1'b0;
      byte_count_next = '0;
    end else begin
      byte_count_next = count_plus[OFFSET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      byte_count   <= '0;
      header_shift <= '0;
      status_word  <= '0;
    end else if (take) begin
      in_payload <= in_payload_next;
      byte_count <= byte_count_next;
      if (!in_payload) begin
        if (byte_count < STATUS_FIRST) begin
          header_shift[byte_count[2:0]*BYTE_W +: BYTE_W] <= rx_byte;
        end else begin
          status_word[byte_count[1:0]*BYTE_W +: BYTE_W] <= rx_byte;
        end
      end
    end
  end

  assign res_valid        = take && in_payload && addr_match;
  assign res.payload_byte = rx_byte;
  assign res.byte_offset  = byte_count;
  assign res.last_byte    = last;
  assign res.frame_length = payload_length;
  assign res.frame_status = status_word;

endmodule

// ----- rtl/afr_out_buffer.sv -----
// ----------------------------------------------------------------------------
// afr_out_buffer: output register with skid stage
// Registers result beats and keeps one more beat aside while the consumer
// stalls, so the input side is held off only when both places are full.
// ----------------------------------------------------------------------------
module afr_out_buffer
  import afr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  afr_result_t           res,
  output logic                  room,
  afr_payload_if.source         payload
);

  logic        main_valid;
  logic        skid_valid;
  afr_result_t main_beat;
  afr_result_t skid_beat;
  logic        main_free;

  assign room      = !skid_valid;
  assign main_free = !main_valid || payload.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        main_beat  <= skid_beat;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= res_valid;
        main_beat  <= res;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_beat  <= res;
    end
  end

  assign payload.valid        = main_valid;
  assign payload.payload_byte = main_beat.payload_byte;
  assign payload.byte_offset  = main_beat.byte_offset;
  assign payload.last_byte    = main_beat.last_byte;
  assign payload.frame_length = main_beat.frame_length;
  assign payload.frame_status = main_beat.frame_status;

endmodule

// ----- rtl/addressed_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// addressed_frame_receiver: byte-serial deframer for addressed frames
// Collects a 12-byte little-endian header (address, length, status) and
// passes on the payload bytes of frames sent to this node or to broadcast.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake      content of one beat
//   -------   ---  -------------  ------------------------------------------
//   rx        in   valid/ready    rx_byte, one received link byte
//   payload   out  valid/ready    payload_byte, byte_offset, last_byte,
//                                 frame_length, frame_status
//   cfg       in   valid/ready    own_address, this node's link address
//
// A new rx beat is accepted in every cycle while the output is drained; a
// payload beat is registered in the output register or the skid stage.
// Reset (rst, synchronous) returns the block to header collection and clears
// own_address to zero. A stalled payload channel is absorbed by an output
// register and a one-beat skid stage; rx.ready drops only once both hold a
// beat. Address writes are always taken and apply from the next byte on.
//
module addressed_frame_receiver
  import afr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  afr_rx_if.sink        rx,
  afr_cfg_if.sink       cfg,
  afr_payload_if.source payload
);

  logic signed [WORD_W-1:0] own_address;
  logic                     room;
  logic                     take;
  logic                     res_valid;
  afr_result_t              res;

  // The address register can be written at any time.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg.valid) begin
      own_address <= cfg.own_address;
    end
  end

  // A byte enters whenever the skid stage is empty, so one beat can always
  // be parked even if the consumer stalls in the same cycle.
  assign rx.ready = room;
  assign take     = rx.valid && room;

  afr_deframer u_deframer (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (rx.rx_byte),
    .own_address (own_address),
    .res_valid   (res_valid),
    .res         (res)
  );

  afr_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .payload   (payload)
  );

endmodule
